[hdl/tvg_pkg.sv]
// ----------------------------------------------------------------------------
// tvg_pkg: shared types and constants of the total variation gradient unit
// Store geometry, request kinds, status codes, register indexes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tvg_pkg;

  localparam int MAX_PIXELS = 4096;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // iteration counts of the shared serial units
  localparam int SQRT_STEPS = 34;
  localparam int CDIV_STEPS = 12;
  localparam int RDIV_STEPS = 17;
  localparam int CNT_W      = 6;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_GRAD = 2'd1,
    KIND_MAG  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SAT   = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TV_WEIGHT  = 3'd4;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_STORE,
    OP_CAPTURE,
    OP_GEO1,
    OP_GEO2,
    OP_DIVX_INIT,
    OP_DIV_STEP,
    OP_DIVY_INIT,
    OP_COORD,
    OP_SITE,
    OP_ADDR1,
    OP_ADDR2,
    OP_MEMRD,
    OP_USE,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_RAT_INIT,
    OP_RAT_ACC,
    OP_MUL,
    OP_FIN,
    OP_FIN_BAD
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GEO1,
    S_GEO2,
    S_CHECK,
    S_DIVX_INIT,
    S_DIVX,
    S_DIVY_INIT,
    S_DIVY,
    S_COORD,
    S_SITE,
    S_ADDR1,
    S_ADDR2,
    S_MEMRD,
    S_USE,
    S_SQ,
    S_SQRT_INIT,
    S_SQRT,
    S_JUDGE,
    S_RAT_INIT,
    S_RAT,
    S_RAT_ACC,
    S_MUL,
    S_FIN,
    S_BAD
  } tvg_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] site;
    logic [1:0] rd_sel;
    logic [1:0] axis;
  } tvg_cmd_t;

  typedef struct packed {
    logic geo_bad;
    logic g_over;
    logic out_free;
  } tvg_stat_t;

endpackage

[hdl/tvg_if.sv]
// ----------------------------------------------------------------------------
// tvg channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tvg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] pixel_index;
  logic signed [15:0] pixel_value;
  logic signed [47:0] prior_value;

  modport source (output valid, kind, pixel_index, pixel_value, prior_value, input ready);
  modport sink   (input valid, kind, pixel_index, pixel_value, prior_value, output ready);
endinterface

interface tvg_out_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] result_value;
  logic [1:0]  status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

interface tvg_cfg_if;
  logic valid;
  logic ready;
  logic [tvg_pkg::CFG_IDX_W-1:0]  index;
  logic [tvg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/tvg_ctrl.sv]
// ----------------------------------------------------------------------------
// tvg_ctrl: request sequencer
// Walks a request through geometry check, coordinate division, four magnitude
// sites (center only for magnitude) with reads, square roots, ratio divisions.
// ----------------------------------------------------------------------------
module tvg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  tvg_pkg::kind_t     in_kind,
  output logic               in_ready,
  output tvg_pkg::tvg_cmd_t  cmd,
  input  tvg_pkg::tvg_stat_t stat
);
  import tvg_pkg::*;

  tvg_state_t       state_r, state_nxt;
  logic [1:0]       site_r, site_nxt;
  logic [1:0]       rd_r, rd_nxt;
  logic [1:0]       ax_r, ax_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             mag_r, mag_nxt;
  logic             accept;
  logic             is_req;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_req   = (in_kind == KIND_GRAD) || (in_kind == KIND_MAG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      site_r  <= 2'd0;
      rd_r    <= 2'd0;
      ax_r    <= 2'd0;
      cnt_r   <= '0;
      mag_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      site_r  <= site_nxt;
      rd_r    <= rd_nxt;
      ax_r    <= ax_nxt;
      cnt_r   <= cnt_nxt;
      mag_r   <= mag_nxt;
    end
  end

  // next state and loop counters
  always_comb begin
    state_nxt = state_r;
    site_nxt  = site_r;
    rd_nxt    = rd_r;
    ax_nxt    = ax_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && is_req) begin
          state_nxt = S_GEO1;
          mag_nxt   = (in_kind == KIND_MAG);
        end
      end
      S_GEO1:  state_nxt = S_GEO2;
      S_GEO2:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = stat.geo_bad ? S_BAD : S_DIVX_INIT;
      S_DIVX_INIT: begin
        cnt_nxt   = '0;
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        if (cnt_r == CNT_W'(CDIV_STEPS - 1)) state_nxt = S_DIVY_INIT;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_DIVY_INIT: begin
        cnt_nxt   = '0;
        state_nxt = S_DIVY;
      end
      S_DIVY: begin
        if (cnt_r == CNT_W'(CDIV_STEPS - 1)) state_nxt = S_COORD;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_COORD: begin
        site_nxt  = 2'd0;
        state_nxt = S_SITE;
      end
      S_SITE: begin
        rd_nxt    = 2'd0;
        state_nxt = S_ADDR1;
      end
      S_ADDR1: state_nxt = S_ADDR2;
      S_ADDR2: state_nxt = S_MEMRD;
      S_MEMRD: state_nxt = S_USE;
      S_USE: begin
        if (rd_r == 2'd0) begin
          rd_nxt    = 2'd1;
          state_nxt = S_ADDR1;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (rd_r == 2'd3) begin
          state_nxt = S_SQRT_INIT;
        end else begin
          rd_nxt    = rd_r + 2'd1;
          state_nxt = S_ADDR1;
        end
      end
      S_SQRT_INIT: begin
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_JUDGE;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_JUDGE: begin
        if (mag_r) begin
          state_nxt = S_MUL;
        end else if (stat.g_over) begin
          ax_nxt    = 2'd0;
          state_nxt = S_RAT_INIT;
        end else if (site_r == 2'd3) begin
          state_nxt = S_MUL;
        end else begin
          site_nxt  = site_r + 2'd1;
          state_nxt = S_SITE;
        end
      end
      S_RAT_INIT: begin
        cnt_nxt   = '0;
        state_nxt = S_RAT;
      end
      S_RAT: begin
        if (cnt_r == CNT_W'(RDIV_STEPS - 1)) state_nxt = S_RAT_ACC;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_RAT_ACC: begin
        // the center site takes one ratio per axis, a neighbor site just one
        if (site_r == 2'd0 && ax_r != 2'd2) begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_RAT_INIT;
        end else if (site_r == 2'd3) begin
          state_nxt = S_MUL;
        end else begin
          site_nxt  = site_r + 2'd1;
          state_nxt = S_SITE;
        end
      end
      S_MUL: state_nxt = S_FIN;
      S_FIN: if (stat.out_free) state_nxt = S_IDLE;
      S_BAD: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // command to the datapath
  always_comb begin
    cmd.site   = site_r;
    cmd.rd_sel = rd_r;
    cmd.axis   = ax_r;
    cmd.op     = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_kind == KIND_LOAD) cmd.op = OP_STORE;
        else if (accept && is_req) cmd.op = OP_CAPTURE;
      end
      S_GEO1:      cmd.op = OP_GEO1;
      S_GEO2:      cmd.op = OP_GEO2;
      S_CHECK:     cmd.op = OP_NOP;
      S_DIVX_INIT: cmd.op = OP_DIVX_INIT;
      S_DIVX:      cmd.op = OP_DIV_STEP;
      S_DIVY_INIT: cmd.op = OP_DIVY_INIT;
      S_DIVY:      cmd.op = OP_DIV_STEP;
      S_COORD:     cmd.op = OP_COORD;
      S_SITE:      cmd.op = OP_SITE;
      S_ADDR1:     cmd.op = OP_ADDR1;
      S_ADDR2:     cmd.op = OP_ADDR2;
      S_MEMRD:     cmd.op = OP_MEMRD;
      S_USE:       cmd.op = OP_USE;
      S_SQ:        cmd.op = OP_SQ;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT_STEP;
      S_JUDGE:     cmd.op = OP_NOP;
      S_RAT_INIT:  cmd.op = OP_RAT_INIT;
      S_RAT:       cmd.op = OP_DIV_STEP;
      S_RAT_ACC:   cmd.op = OP_RAT_ACC;
      S_MUL:       cmd.op = OP_MUL;
      S_FIN:       cmd.op = stat.out_free ? OP_FIN : OP_NOP;
      S_BAD:       cmd.op = stat.out_free ? OP_FIN_BAD : OP_NOP;
      default:     cmd.op = OP_NOP;
    endcase
  end

  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> cnt_r < CNT_W'(SQRT_STEPS))
    else $error("square root step count overran");

  a_center_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_USE && rd_r == 2'd0 |=> state_r == S_ADDR1 && rd_r == 2'd1)
    else $error("center read not followed by first neighbor read");

  a_fin_return: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN || state_r == S_BAD) && stat.out_free |=> state_r == S_IDLE)
    else $error("result delivered without return to idle");

endmodule

[hdl/tvg_datapath.sv]
// ----------------------------------------------------------------------------
// tvg_datapath: registers, pixel store and arithmetic of the gradient unit
// Holds the configuration registers, the pixel memory, a shared serial
// divider, a serial square root unit, the accumulators and the result register.
// ----------------------------------------------------------------------------
module tvg_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [11:0]                        in_pixel_index,
  input  logic signed [15:0]                 in_pixel_value,
  input  logic signed [47:0]                 in_prior_value,
  input  tvg_pkg::kind_t                     in_kind,
  input  logic                               cfg_valid,
  input  logic [tvg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tvg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               cfg_ready,
  input  tvg_pkg::tvg_cmd_t                  cmd,
  output tvg_pkg::tvg_stat_t                 stat,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [47:0]                 out_result_value,
  output logic [1:0]                         out_status
);
  import tvg_pkg::*;

  localparam int AW2 = ADDR_W + 13;

  logic [12:0] sx_r, sy_r, sz_r;
  logic [16:0] lim_r;
  logic [15:0] w_r;

  logic [11:0]        idx_r;
  logic signed [47:0] prior_r;
  logic               mag_r;
  logic [25:0]        sxy_r;
  logic [38:0]        tot_r;

  logic [34:0] drem_r;
  logic [11:0] dnum_r;
  logic [33:0] dden_r;
  logic [16:0] dq_r;
  logic        dneg_r;

  logic [11:0] cx_r, cy_r, cz_r;
  logic [11:0] px_r, py_r, pz_r;
  logic [ADDR_W-1:0] at_r, addr_r;
  logic [15:0] rdata_r;
  logic signed [15:0] v0_r;
  logic signed [16:0] d_r;
  logic signed [16:0] dsave_r [3];
  logic [34:0] sq_r;

  logic [35:0] sv_r;
  logic [35:0] srem_r;
  logic [33:0] sroot_r;

  logic signed [20:0] sum_r;
  logic [49:0]        mprod_r;
  logic signed [37:0] sprod_r;

  logic               out_valid_r;
  logic signed [47:0] out_res_r;
  logic [1:0]         out_st_r;

  logic [15:0] mem [MAX_PIXELS];

  function automatic logic [11:0] step_fwd(input logic [11:0] c, input logic [12:0] n);
    logic [12:0] c1;
    c1 = {1'b0, c} + 13'd1;
    return (c1 >= n) ? 12'd0 : c1[11:0];
  endfunction

  function automatic logic [11:0] step_back(input logic [11:0] c, input logic [12:0] n);
    logic [12:0] nm1;
    nm1 = n - 13'd1;
    return (c == 12'd0) ? nm1[11:0] : c - 12'd1;
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r  <= 13'd64;
      sy_r  <= 13'd64;
      sz_r  <= 13'd1;
      lim_r <= 17'd0;
      w_r   <= 16'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE_X:     sx_r  <= cfg_data[12:0];
        REG_SIZE_Y:     sy_r  <= cfg_data[12:0];
        REG_SIZE_Z:     sz_r  <= cfg_data[12:0];
        REG_GRAD_LIMIT: lim_r <= cfg_data;
        REG_TV_WEIGHT:  w_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pixel store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE && 32'(in_pixel_index) < MAX_PIXELS)
      mem[ADDR_W'(in_pixel_index)] <= in_pixel_value;
    if (cmd.op == OP_MEMRD)
      rdata_r <= mem[addr_r];
  end

  // point of the current site and of the current read
  logic [11:0] site_x, site_y, site_z;
  logic [11:0] sel_x, sel_y, sel_z;
  logic [1:0]  rd_axis;

  always_comb begin
    site_x = cx_r;
    site_y = cy_r;
    site_z = cz_r;
    unique case (cmd.site)
      2'd1:    site_x = step_back(cx_r, sx_r);
      2'd2:    site_y = step_back(cy_r, sy_r);
      2'd3:    site_z = step_back(cz_r, sz_r);
      default: ;
    endcase
  end

  assign rd_axis = cmd.rd_sel - 2'd1;

  always_comb begin
    sel_x = px_r;
    sel_y = py_r;
    sel_z = pz_r;
    if (cmd.rd_sel != 2'd0) begin
      unique case (rd_axis)
        2'd0:    sel_x = step_fwd(px_r, sx_r);
        2'd1:    sel_y = step_fwd(py_r, sy_r);
        default: sel_z = step_fwd(pz_r, sz_r);
      endcase
    end
  end

  // serial divider and square root step logic
  logic [34:0] div_rem2;
  logic        div_take;
  logic [37:0] sq_remn, sq_trial;
  logic        sq_take;

  assign div_rem2 = {drem_r[33:0], dnum_r[11]};
  assign div_take = div_rem2 >= {1'b0, dden_r};
  assign sq_remn  = {srem_r, sv_r[35:34]};
  assign sq_trial = {2'b00, sroot_r, 2'b01};
  assign sq_take  = sq_remn >= sq_trial;

  logic signed [16:0] rat_diff;
  logic [16:0]        rat_abs;
  logic signed [20:0] rat_q;
  logic signed [33:0] d_sq;
  logic [25:0]        at_full;
  logic [AW2-1:0]     addr_full;
  logic signed [29:0] sprod_sh;
  logic signed [48:0] grad_sum;
  logic [32:0]        lim_q;

  always_comb begin
    if (cmd.site == 2'd0) rat_diff = dsave_r[cmd.axis];
    else rat_diff = -dsave_r[cmd.site - 2'd1];
  end

  assign rat_abs   = rat_diff[16] ? 17'(-rat_diff) : 17'(rat_diff);
  assign rat_q     = $signed({4'b0000, dq_r});
  assign d_sq      = d_r * d_r;
  assign at_full   = 26'(sel_z) * 26'(sy_r) + 26'(sel_y);
  assign addr_full = AW2'(at_r) * AW2'(sx_r) + AW2'(sel_x);
  assign sprod_sh  = 30'(sprod_r >>> 8);
  assign grad_sum  = $signed({prior_r[47], prior_r}) + 49'(sprod_sh);
  assign lim_q     = {lim_r, 16'd0};

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        idx_r   <= in_pixel_index;
        prior_r <= in_prior_value;
        mag_r   <= (in_kind == KIND_MAG);
        sum_r   <= '0;
      end
      OP_GEO1: sxy_r <= 26'(sx_r) * 26'(sy_r);
      OP_GEO2: tot_r <= 39'(sxy_r) * 39'(sz_r);
      OP_DIVX_INIT: begin
        drem_r <= '0;
        dq_r   <= '0;
        dnum_r <= idx_r;
        dden_r <= 34'(sx_r);
      end
      OP_DIV_STEP: begin
        drem_r <= div_take ? div_rem2 - {1'b0, dden_r} : div_rem2;
        dq_r   <= {dq_r[15:0], div_take};
        dnum_r <= {dnum_r[10:0], 1'b0};
      end
      OP_DIVY_INIT: begin
        cx_r   <= drem_r[11:0];
        drem_r <= '0;
        dq_r   <= '0;
        dnum_r <= dq_r[11:0];
        dden_r <= 34'(sy_r);
      end
      OP_COORD: begin
        cy_r <= drem_r[11:0];
        cz_r <= dq_r[11:0];
      end
      OP_SITE: begin
        px_r <= site_x;
        py_r <= site_y;
        pz_r <= site_z;
        sq_r <= '0;
      end
      OP_ADDR1: at_r   <= ADDR_W'(at_full);
      OP_ADDR2: addr_r <= addr_full[ADDR_W-1:0];
      OP_USE: begin
        if (cmd.rd_sel == 2'd0) begin
          v0_r <= $signed(rdata_r);
        end else begin
          d_r <= $signed({v0_r[15], v0_r}) - $signed({rdata_r[15], rdata_r});
          dsave_r[rd_axis] <= $signed({v0_r[15], v0_r}) - $signed({rdata_r[15], rdata_r});
        end
      end
      OP_SQ: sq_r <= sq_r + {1'b0, d_sq};
      OP_SQRT_INIT: begin
        sv_r    <= {1'b0, sq_r};
        srem_r  <= '0;
        sroot_r <= '0;
      end
      OP_SQRT_STEP: begin
        srem_r  <= sq_take ? 36'(sq_remn - sq_trial) : sq_remn[35:0];
        sroot_r <= {sroot_r[32:0], sq_take};
        sv_r    <= {sv_r[33:0], 2'b00};
      end
      OP_RAT_INIT: begin
        // quotient stays below 2^17, so start with the top bits preloaded
        drem_r <= {4'b0000, rat_abs[15:0], 15'd0};
        dneg_r <= rat_diff[16];
        dq_r   <= '0;
        dnum_r <= '0;
        dden_r <= sroot_r;
      end
      OP_RAT_ACC: sum_r <= dneg_r ? sum_r - rat_q : sum_r + rat_q;
      OP_MUL: begin
        mprod_r <= 50'(sroot_r) * 50'(w_r);
        sprod_r <= 38'(sum_r) * $signed({22'd0, w_r});
      end
      default: ;
    endcase
  end

  assign stat.geo_bad  = (sx_r == 13'd0) || (sy_r == 13'd0) || (sz_r == 13'd0) ||
                         (tot_r > 39'(MAX_PIXELS)) || (39'(idx_r) >= tot_r);
  assign stat.g_over   = {1'b0, sroot_r} > {2'b00, lim_q};
  assign stat.out_free = !out_valid_r || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN || cmd.op == OP_FIN_BAD) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN_BAD) begin
      out_res_r <= '0;
      out_st_r  <= STAT_RANGE;
    end else if (cmd.op == OP_FIN) begin
      if (mag_r) begin
        out_res_r <= 48'(mprod_r[49:8]);
        out_st_r  <= STAT_OK;
      end else if (!grad_sum[48] && grad_sum[47]) begin
        out_res_r <= {1'b0, {47{1'b1}}};
        out_st_r  <= STAT_SAT;
      end else if (grad_sum[48] && !grad_sum[47]) begin
        out_res_r <= {1'b1, 47'd0};
        out_st_r  <= STAT_SAT;
      end else begin
        out_res_r <= grad_sum[47:0];
        out_st_r  <= STAT_OK;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_st_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN || cmd.op == OP_FIN_BAD) |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_ratio_gate: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_RAT_INIT |-> stat.g_over)
    else $error("ratio started at a site below the limit");

  a_geo_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_SITE |-> !stat.geo_bad)
    else $error("site walk on bad geometry");

endmodule

[hdl/total_variation_gradient_unit.sv]
// ----------------------------------------------------------------------------
// total_variation_gradient_unit: periodic total variation gradient engine
// Loads pixels into a store and answers gradient and magnitude requests.
// ----------------------------------------------------------------------------
// Channels: in_ch carries loads (kind 0) and requests (kind 1 gradient, kind 2
// magnitude); out_ch returns one result per request, none per load or kind 3;
// cfg_ch writes size_x, size_y, size_z, grad_limit and tv_weight; the user
// must write them only while idle, which the block itself does not enforce.
// A gradient request runs three ratio divisions at the center site, one per
// axis, when its magnitude exceeds the limit, and one at each neighbor site
// that does. A request with bad geometry answers after the geometry check.
// Request time is set by the 34-step serial square root run once per site,
// the 17-step serial divider for each ratio, and the address/read sequence
// through the single store port, sixteen reads per gradient request.
// Requests are taken one at a time; a new item is accepted while the previous
// result still waits in the output register, and a finished request holds in
// its final state while out_ch stalls.
// Reset clears the controller and result valid and restores register
// defaults; the store holds whatever was loaded and needs no clearing pass.
// ----------------------------------------------------------------------------
module total_variation_gradient_unit (
  input logic      clk,
  input logic      rst_n,
  tvg_in_if.sink   in_ch,
  tvg_out_if.source out_ch,
  tvg_cfg_if.sink  cfg_ch
);
  import tvg_pkg::*;

  tvg_cmd_t  cmd;
  tvg_stat_t stat;
  kind_t     in_kind;

  assign in_kind = kind_t'(in_ch.kind);

  tvg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_kind),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tvg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_pixel_index   (in_ch.pixel_index),
    .in_pixel_value   (in_ch.pixel_value),
    .in_prior_value   (in_ch.prior_value),
    .in_kind          (in_kind),
    .cfg_valid        (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .cfg_ready        (cfg_ch.ready),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_result_value (out_ch.result_value),
    .out_status       (out_ch.status)
  );

endmodule
